// File: sv/running_median_two_heaps_macros.svh
// Assertion macros shared by the checker
`ifndef RUNNING_MEDIAN_TWO_HEAPS_MACROS_SVH
`define RUNNING_MEDIAN_TWO_HEAPS_MACROS_SVH

// Clocked implication, disabled during reset
`define RMH_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the following cycle
`define RMH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/rmh_pkg.sv
package rmh_pkg;
  localparam int unsigned MedianBits = 19;
  localparam int unsigned CountBits  = 11;
  // output tdata width: median, count, dropped, padded to bytes
  localparam int unsigned OutDataBits = ((MedianBits + CountBits + 1 + 7) / 8) * 8;

  typedef enum logic [1:0] {
    HEAP_LOWER = 2'd0,
    HEAP_UPPER = 2'd1
  } heap_sel_e;
endpackage

// File: sv/running_median_two_heaps.sv
// Running median over a stream of signed samples, kept as a lower max-heap and an
// upper min-heap, each in its own synchronous RAM of CAPACITY/2+2 words with one write
// and one read port. Each accepted request returns twice the median (sum of both tops
// for an even count, twice the lower top for an odd count), the count held, and a drop
// flag once the store is full (the sample is then ignored). One sample runs up to three
// heap operations: a push, then a push and a pop to rebalance. A push moves one level
// per cycle, and a pop moves one level per pass through S_POPC1 and S_POPC2, each
// waiting on the RAM read port; a dropped sample skips the heaps. One request is in
// work at a time: the result waits in an output register, and the next request is
// accepted from the cycle after the result is taken.
module running_median_two_heaps #(
  parameter int unsigned CAPACITY    = 1024,
  parameter int unsigned SAMPLE_BITS = 18
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [SAMPLE_BITS-1:0] sample, zero fill to bytes
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [18:0] median_twice, [29:19] count, [30] dropped, [31] zero
  output logic [rmh_pkg::OutDataBits-1:0]     m_axis_tdata
);
  import rmh_pkg::*;

  localparam int unsigned Depth  = CAPACITY / 2 + 2;
  localparam int unsigned AW     = $clog2(Depth);
  localparam int unsigned SW     = AW + 1;
  localparam int unsigned TW     = $clog2(CAPACITY + 1);
  localparam int unsigned SB     = SAMPLE_BITS;

  // sequencer codes
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECIDE = 4'd1;   // lower top is back, pick target heap
  localparam logic [3:0] S_PUSHR  = 4'd2;   // issue first parent read, or write root
  localparam logic [3:0] S_PUSHC  = 4'd3;   // compare with parent, read next parent
  localparam logic [3:0] S_NEXT   = 4'd4;   // next operation or finish
  localparam logic [3:0] S_BALT   = 4'd5;   // donor top is back, start its push
  localparam logic [3:0] S_POPL   = 4'd6;   // read last element
  localparam logic [3:0] S_POPV   = 4'd7;   // latch last, read left child
  localparam logic [3:0] S_POPC1  = 4'd8;   // left child back, read right child
  localparam logic [3:0] S_POPC2  = 4'd9;   // both children known
  localparam logic [3:0] S_POPW   = 4'd10;  // hole reached a leaf, place last value
  localparam logic [3:0] S_RES    = 4'd11;
  localparam logic [3:0] S_OUT    = 4'd12;

  // operation phase codes
  localparam logic [1:0] P_INS   = 2'd0;
  localparam logic [1:0] P_BPUSH = 2'd1;
  localparam logic [1:0] P_BPOP  = 2'd2;

  logic [3:0]           state_q, state_d;
  logic [SW-1:0]        lsize_q, lsize_d, usize_q, usize_d;
  logic signed [SB-1:0] val_q, val_d, c1_q, c1_d;
  logic [AW-1:0]        idx_q, idx_d, cidx_q, cidx_d;
  logic [SW-1:0]        hsize_q, hsize_d;   // size of heap under pop
  heap_sel_e            heap_q, heap_d, donor_q, donor_d;
  logic [1:0]           phase_q, phase_d;
  logic                 drop_q, drop_d;
  logic [OutDataBits-1:0] out_q, out_d;

  // RAM ports
  logic signed [SB-1:0] lmem [Depth];
  logic signed [SB-1:0] umem [Depth];
  logic                 we;
  logic [AW-1:0]        waddr, raddr;
  logic signed [SB-1:0] wdata, rd_l_q, rd_u_q, rd;

  always_ff @(posedge clk_i) begin
    if (we && heap_q == HEAP_LOWER) begin
      lmem[waddr] <= wdata;
    end
    rd_l_q <= lmem[raddr];
  end
  always_ff @(posedge clk_i) begin
    if (we && heap_q == HEAP_UPPER) begin
      umem[waddr] <= wdata;
    end
    rd_u_q <= umem[raddr];
  end
  assign rd = (heap_q == HEAP_LOWER) ? rd_l_q : rd_u_q;

  function automatic logic above(heap_sel_e h, logic signed [SB-1:0] a,
                                 logic signed [SB-1:0] b);
    return (h == HEAP_LOWER) ? (a > b) : (a < b);
  endfunction

  logic [TW-1:0]                total;
  logic [AW-1:0]                pidx, pcidx, bi;
  logic [SW-1:0]                c_right, nl;
  logic signed [SB-1:0]         bv;
  logic signed [SB:0]           msum;
  logic signed [MedianBits-1:0] med;

  assign total   = TW'(lsize_q) + TW'(usize_q);
  assign pidx    = (idx_q - AW'(1)) >> 1;
  assign pcidx   = (cidx_q - AW'(1)) >> 1;
  assign c_right = {1'b0, cidx_q} + SW'(1);

  always_comb begin
    state_d = state_q; lsize_d = lsize_q; usize_d = usize_q;
    val_d = val_q; c1_d = c1_q; idx_d = idx_q; cidx_d = cidx_q; hsize_d = hsize_q;
    heap_d = heap_q; donor_d = donor_q; phase_d = phase_q; drop_d = drop_q;
    out_d = out_q;
    we = 1'b0; waddr = idx_q; wdata = val_q; raddr = '0;
    bv = c1_q; bi = cidx_q; nl = '0; msum = '0; med = '0;
    unique case (state_q)
      S_IDLE: begin
        // address 0 is read on both RAMs while idle
        if (s_axis_tvalid) begin
          val_d = s_axis_tdata[SB-1:0];
          drop_d = (total >= TW'(CAPACITY));
          phase_d = P_INS;
          state_d = (total >= TW'(CAPACITY)) ? S_RES : S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (lsize_q == '0 || val_q < rd_l_q) begin
          heap_d = HEAP_LOWER; idx_d = AW'(lsize_q); lsize_d = lsize_q + SW'(1);
        end else begin
          heap_d = HEAP_UPPER; idx_d = AW'(usize_q); usize_d = usize_q + SW'(1);
        end
        state_d = S_PUSHR;
      end
      S_PUSHR: begin
        if (idx_q == '0) begin
          we = 1'b1; state_d = S_NEXT;
        end else begin
          raddr = pidx; cidx_d = pidx;
          state_d = S_PUSHC;
        end
      end
      S_PUSHC: begin
        if (above(heap_q, val_q, rd)) begin
          we = 1'b1; wdata = rd;
          idx_d = cidx_q;
          if (cidx_q == '0) begin
            state_d = S_PUSHR;
          end else begin
            raddr = pcidx; cidx_d = pcidx;
          end
        end else begin
          we = 1'b1; state_d = S_NEXT;
        end
      end
      S_NEXT: begin
        // tops are read here for the rebalance or the result
        if (phase_q == P_INS) begin
          if (lsize_q > usize_q + SW'(1)) begin
            donor_d = HEAP_LOWER; phase_d = P_BPUSH; state_d = S_BALT;
          end else if (lsize_q < usize_q) begin
            donor_d = HEAP_UPPER; phase_d = P_BPUSH; state_d = S_BALT;
          end else begin
            state_d = S_RES;
          end
        end else if (phase_q == P_BPUSH) begin
          phase_d = P_BPOP; heap_d = donor_q;
          if (donor_q == HEAP_LOWER) begin
            lsize_d = lsize_q - SW'(1); hsize_d = lsize_q - SW'(1);
          end else begin
            usize_d = usize_q - SW'(1); hsize_d = usize_q - SW'(1);
          end
          state_d = S_POPL;
        end else begin
          state_d = S_RES;
        end
      end
      S_BALT: begin
        if (donor_q == HEAP_LOWER) begin
          val_d = rd_l_q; heap_d = HEAP_UPPER;
          idx_d = AW'(usize_q); usize_d = usize_q + SW'(1);
        end else begin
          val_d = rd_u_q; heap_d = HEAP_LOWER;
          idx_d = AW'(lsize_q); lsize_d = lsize_q + SW'(1);
        end
        state_d = S_PUSHR;
      end
      S_POPL: begin
        if (hsize_q == '0) begin
          state_d = S_NEXT;
        end else begin
          raddr = AW'(hsize_q);
          state_d = S_POPV;
        end
      end
      S_POPV: begin
        val_d = rd; idx_d = '0;
        if (hsize_q > SW'(1)) begin
          raddr = AW'(1); cidx_d = AW'(1);
          state_d = S_POPC1;
        end else begin
          we = 1'b1; waddr = '0; wdata = rd;
          state_d = S_NEXT;
        end
      end
      S_POPC1: begin
        c1_d = rd;
        if (c_right < hsize_q) begin
          raddr = AW'(c_right);
          state_d = S_POPC2;
        end else if (above(heap_q, rd, val_q)) begin
          // only child is the last slot, a leaf
          we = 1'b1; wdata = rd; idx_d = cidx_q;
          state_d = S_POPW;
        end else begin
          we = 1'b1; state_d = S_NEXT;
        end
      end
      S_POPC2: begin
        if (above(heap_q, rd, c1_q)) begin
          bv = rd; bi = cidx_q + AW'(1);
        end
        nl = {bi, 1'b1};
        if (above(heap_q, bv, val_q)) begin
          we = 1'b1; wdata = bv; idx_d = bi;
          if (nl < hsize_q) begin
            raddr = AW'(nl); cidx_d = AW'(nl); state_d = S_POPC1;
          end else begin
            state_d = S_POPW;
          end
        end else begin
          we = 1'b1; state_d = S_NEXT;
        end
      end
      S_POPW: begin
        we = 1'b1; state_d = S_NEXT;
      end
      S_RES: begin
        msum = total[0] ? {rd_l_q, 1'b0} : ({rd_l_q[SB-1], rd_l_q} + {rd_u_q[SB-1], rd_u_q});
        if (total != '0) med = MedianBits'(msum);
        out_d = OutDataBits'({drop_q, CountBits'(total), med});
        state_d = S_OUT;
      end
      S_OUT: begin
        if (m_axis_tready) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_axis_tdata  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      lsize_q <= '0;
      usize_q <= '0;
      phase_q <= P_INS;
      heap_q  <= HEAP_LOWER;
      donor_q <= HEAP_LOWER;
    end else begin
      state_q <= state_d;
      lsize_q <= lsize_d;
      usize_q <= usize_d;
      phase_q <= phase_d;
      heap_q  <= heap_d;
      donor_q <= donor_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d; c1_q <= c1_d; idx_q <= idx_d; cidx_q <= cidx_d;
    hsize_q <= hsize_d; drop_q <= drop_d; out_q <= out_d;
  end
endmodule

// File: sv/rmh_checker.sv
module rmh_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);
`include "running_median_two_heaps_macros.svh"

  `RMH_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result dropped while stalled")
  `RMH_ASSERT_IMP(a_count_nonzero, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[29:19] != 11'd0, "result with empty store")
  `RMH_ASSERT_IMP(a_one_in_flight, clk_i, rst_ni, m_axis_tvalid, !s_axis_tready, "request taken while result pending")
  `RMH_ASSERT_NEXT(a_req_starts, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request not started")
endmodule

bind running_median_two_heaps rmh_checker u_rmh_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);

// File: verif/tb_running_median_two_heaps.sv
`timescale 1ns / 100ps

class median_scoreboard;
  int lower_q[$];
  int upper_q[$];
  logic [31:0] pending_q[$];
  int mismatches;
  int checked;
  int drops;

  function int top_of(ref int q[$]);
    return q[0];
  endfunction

  // heaps modeled as sorted queues: lower ascending (top = last), upper ascending (top = first)
  function void note_request(logic signed [17:0] sample);
    int s;
    int total;
    int med2;
    bit drop;
    int idx;
    logic [18:0] m;
    logic [10:0] c;
    s = sample;
    total = lower_q.size() + upper_q.size();
    drop = 0;
    if (total >= 1024) begin
      drop = 1;
      drops++;
    end else begin
      if (lower_q.size() == 0 || s < lower_q[lower_q.size()-1]) begin
        idx = 0;
        while (idx < lower_q.size() && lower_q[idx] <= s) idx++;
        lower_q.insert(idx, s);
      end else begin
        idx = 0;
        while (idx < upper_q.size() && upper_q[idx] <= s) idx++;
        upper_q.insert(idx, s);
      end
      if (lower_q.size() > upper_q.size() + 1) begin
        upper_q.push_front(lower_q.pop_back());
      end else if (lower_q.size() < upper_q.size()) begin
        lower_q.insert(lower_q.size(), upper_q.pop_front());
      end
    end
    total = lower_q.size() + upper_q.size();
    if (total == 0) med2 = 0;
    else if (total % 2) med2 = 2 * lower_q[lower_q.size()-1];
    else med2 = lower_q[lower_q.size()-1] + upper_q[0];
    m = med2[18:0];
    c = total[10:0];
    pending_q.insert(pending_q.size(), {1'b0, drop, c, m});
  endfunction

  function void check_result(logic [31:0] got);
    logic [31:0] exp;
    if (pending_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %h", got);
      return;
    end
    exp = pending_q.pop_front();
    checked++;
    if (got[18:0] !== exp[18:0] || got[29:19] !== exp[29:19] || got[30] !== exp[30]) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch #%0d: exp med2=%0d cnt=%0d drop=%0b, got med2=%0d cnt=%0d drop=%0b",
                 checked, $signed(exp[18:0]), exp[29:19], exp[30],
                 $signed(got[18:0]), got[29:19], got[30]);
    end
  endfunction
endclass

module tb_running_median_two_heaps;
  localparam int NumRandom = 782;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;

  median_scoreboard sb;
  int unsigned cycles;
  bit sending_done;

  running_median_two_heaps u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_sample(logic signed [17:0] v, bit no_gap);
    int g;
    g = no_gap ? 0 : gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, v};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_request(v);
  endtask

  function automatic logic signed [17:0] rand_sample(int mode);
    case (mode)
      0: return 18'($urandom_range(0, 200000) - 100000);
      1: return 18'($urandom_range(0, 20) - 10);
      2: return $urandom_range(0, 1) ? 18'sd100000 : -18'sd100000;
      default: return 18'($urandom);
    endcase
  endfunction

  // receiver with random stalls; about five eighths of results are taken without a gap
  initial begin
    int g;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      g = ($urandom_range(0, 3) == 0) ? 0 : gap_len();
      if (g > 0) begin
        m_axis_tready <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      sb.check_result(m_axis_tdata);
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > 400000) begin
        $display("timeout after %0d cycles", cycles);
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    logic signed [17:0] directed [];
    int mode;
    int n;
    directed = '{18'sd0, 18'sd100000, -18'sd100000, 18'sd5, 18'sd5,
      18'sd5, -18'sd1, 18'sd131071, 18'sh20000, 18'sd3, 18'sd4, 18'sd4, -18'sd7,
      18'sd99999, -18'sd99999, 18'sd1, 18'sd0, 18'sd2};
    sb = new();
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) send_sample(directed[i], 0);
    // random part: value ranges are redrawn every hundred samples
    for (n = 0; n < NumRandom; n++) begin
      if (n % 100 == 0) mode = $urandom_range(0, 3);
      send_sample(rand_sample(mode), (n / 50) % 4 == 3);
    end
    s_axis_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    $display("checked %0d medians over %0d samples with random stalls, %0d hit a full store",
             sb.checked, directed.size() + NumRandom, sb.drops);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("mismatches: %0d", sb.mismatches);
      $display("FAIL");
    end
    $finish;
  end
endmodule

// File: filelist.f
+incdir+sv
sv/rmh_pkg.sv
sv/running_median_two_heaps.sv
sv/rmh_checker.sv
verif/tb_running_median_two_heaps.sv
